FILE: design/hdlcd_pkg.sv
package hdlcd_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;
  localparam int unsigned LEN_W       = 13;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

  // Frame status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_BAD_ESC = 2'd2;
  localparam logic [1:0] STAT_CRC_ERR = 2'd3;

  // One byte of CRC-16/X.25, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

FILE: design/hdlcd_if.sv
interface hdlcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface hdlcd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_done;
  logic [1:0]  frame_status;
  logic [12:0] payload_length;

  modport source (output valid, output payload_byte, output payload_valid,
                  output frame_done, output frame_status, output payload_length,
                  input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input frame_done, input frame_status, input payload_length,
                  output ready);
endinterface

FILE: design/async_hdlc_deframer_crc16_top.sv
// Channel | Dir | Handshake           | Item contents
// in_ch   | in  | valid/ready         | rx_byte[7:0], end_of_buffer
// out_ch  | out | valid/ready         | payload_byte, payload_valid, frame_done,
//         |     |                     | frame_status[1:0], payload_length[12:0]
//
// One item per cycle sustained while out_ch.ready stays high. An accepted item
// waits in the input register; unstuffing, the hold pair and a byte-wide CRC step
// then load the result register, from which the result is presented on out_ch.
// rst_n is synchronous and active low; it clears frame state and both valids.
// A stalled full result register holds the input register, result or not;
// in_ch.ready drops only when both are full and the result is not taken.
module async_hdlc_deframer_crc16_top (
  input  logic clk,
  input  logic rst_n,
  hdlcd_in_if.sink    in_ch,
  hdlcd_out_if.source out_ch
);
  import hdlcd_pkg::*;

  // Input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Frame state
  logic             at_start_r,  at_start_nxt;
  logic             start_ok_r,  start_ok_nxt;
  logic [2:0]       raw_cnt_r,   raw_cnt_nxt;
  logic             esc_r,       esc_nxt;
  logic             stopped_r,   stopped_nxt;
  logic [7:0]       hold0_r,     hold0_nxt;
  logic [7:0]       hold1_r,     hold1_nxt;
  logic [1:0]       hold_cnt_r,  hold_cnt_nxt;
  logic [LEN_W-1:0] dec_cnt_r,   dec_cnt_nxt;
  logic [15:0]      crc_r,       crc_nxt;

  // Result register
  logic             out_v_r;
  logic             res_v;
  logic [7:0]       pay_byte_r,  pay_byte_nxt;
  logic             pay_v_r,     pay_v_nxt;
  logic             done_r,      done_nxt;
  logic [1:0]       status_r,    status_nxt;
  logic [LEN_W-1:0] len_r,       len_nxt;

  logic       adv;
  logic       push;
  logic [7:0] push_byte;
  logic [15:0] fcs_rx;

  // Advance the input register whenever the result slot is free or being taken
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;
  assign fcs_rx      = {hold1_r, hold0_r};

  always_comb begin
    at_start_nxt = at_start_r;
    start_ok_nxt = start_ok_r;
    raw_cnt_nxt  = raw_cnt_r;
    esc_nxt      = esc_r;
    stopped_nxt  = stopped_r;
    hold0_nxt    = hold0_r;
    hold1_nxt    = hold1_r;
    hold_cnt_nxt = hold_cnt_r;
    dec_cnt_nxt  = dec_cnt_r;
    crc_nxt      = crc_r;
    res_v        = 1'b0;
    pay_byte_nxt = 8'h00;
    pay_v_nxt    = 1'b0;
    done_nxt     = 1'b0;
    status_nxt   = STAT_OK;
    len_nxt      = '0;
    push         = 1'b0;
    push_byte    = in_byte_r;

    if (in_last_r) begin
      // Close the frame: flag and length checks first, then escape, then FCS count, then CRC
      res_v    = 1'b1;
      done_nxt = 1'b1;
      if (raw_cnt_r < 3'd3 || !start_ok_r || at_start_r || in_byte_r != FLAG_BYTE) begin
        status_nxt = STAT_INVALID;
      end else if (esc_r && !stopped_r) begin
        status_nxt = STAT_BAD_ESC;
      end else if (hold_cnt_r < 2'd2) begin
        status_nxt = STAT_INVALID;
      end else begin
        status_nxt = (fcs_rx == ~crc_r) ? STAT_OK : STAT_CRC_ERR;
        len_nxt    = dec_cnt_r;
      end
      at_start_nxt = 1'b1;
      start_ok_nxt = 1'b0;
      raw_cnt_nxt  = '0;
      esc_nxt      = 1'b0;
      stopped_nxt  = 1'b0;
      hold_cnt_nxt = '0;
      dec_cnt_nxt  = '0;
      crc_nxt      = CRC_INIT;
    end else begin
      if (raw_cnt_r != 3'd7) raw_cnt_nxt = raw_cnt_r + 3'd1;
      if (at_start_r) begin
        at_start_nxt = 1'b0;
        start_ok_nxt = (in_byte_r == FLAG_BYTE);
      end else if (start_ok_r && !stopped_r) begin
        if (esc_r) begin
          esc_nxt   = 1'b0;
          push      = 1'b1;
          push_byte = in_byte_r ^ ESC_XOR;
        end else if (in_byte_r == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else if (in_byte_r == FLAG_BYTE) begin
          stopped_nxt = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
    end

    // Hold pair: the oldest byte leaves once two are held
    if (push) begin
      if (hold_cnt_r == 2'd2) begin
        res_v        = 1'b1;
        pay_v_nxt    = 1'b1;
        pay_byte_nxt = hold0_r;
        crc_nxt      = crc_byte(crc_r, hold0_r);
        if (dec_cnt_r < LEN_MAX) dec_cnt_nxt = dec_cnt_r + LEN_W'(1);
        hold0_nxt    = hold1_r;
        hold1_nxt    = push_byte;
      end else begin
        if (hold_cnt_r[0]) hold1_nxt = push_byte;
        else               hold0_nxt = push_byte;
        hold_cnt_nxt = hold_cnt_r + 2'd1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      at_start_r <= 1'b1;
      start_ok_r <= 1'b0;
      raw_cnt_r  <= '0;
      esc_r      <= 1'b0;
      stopped_r  <= 1'b0;
      hold_cnt_r <= '0;
      dec_cnt_r  <= '0;
      crc_r      <= CRC_INIT;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (adv) begin
        out_v_r    <= res_v;
        at_start_r <= at_start_nxt;
        start_ok_r <= start_ok_nxt;
        raw_cnt_r  <= raw_cnt_nxt;
        esc_r      <= esc_nxt;
        stopped_r  <= stopped_nxt;
        hold_cnt_r <= hold_cnt_nxt;
        dec_cnt_r  <= dec_cnt_nxt;
        crc_r      <= crc_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
      in_last_r <= in_ch.end_of_buffer;
    end
    if (adv) begin
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
    end
    if (adv && res_v) begin
      pay_byte_r <= pay_byte_nxt;
      pay_v_r    <= pay_v_nxt;
      done_r     <= done_nxt;
      status_r   <= status_nxt;
      len_r      <= len_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.payload_byte   = pay_byte_r;
  assign out_ch.payload_valid  = pay_v_r;
  assign out_ch.frame_done     = done_r;
  assign out_ch.frame_status   = status_r;
  assign out_ch.payload_length = len_r;

  // A result is either a payload byte or a frame status, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (pay_v_r != done_r))
    else $error("result carries both or neither payload and status");

  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_cnt_r != 2'd3)
    else $error("hold count out of range");

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    dec_cnt_r <= LEN_MAX)
    else $error("decoded count passed saturation");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (at_start_r && hold_cnt_r == 2'd0 && crc_r == CRC_INIT
                            && out_v_r && done_r))
    else $error("frame state not cleared after final byte");

endmodule

FILE: bench/tb_async_hdlc_deframer_crc16_top.sv
module tb_async_hdlc_deframer_crc16_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_STALL   = 80;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned QUIET_FROM   = 1400;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One result item as the block presents it on out_ch.
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             payload_valid;
    logic             frame_done;
    logic [1:0]       frame_status;
    logic [LEN_W-1:0] payload_length;
  } deframe_result_t;

  typedef logic [7:0] byte_q_t[$];

  // Shapes of random buffers; good frames dominate so that decoding goes deep.
  typedef enum {
    FK_GOOD, FK_CRC_ERR, FK_INNER_FLAG, FK_DANGLING_ESC, FK_BAD_END, FK_BAD_START, FK_NOISE
  } frame_kind_t;

  // CRC-16/X.25, one byte, bits taken LSB first.
  function automatic logic [15:0] crc16_x25_advance(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // Frame-level model of the deframer plus the store of pending results.
  class deframe_scoreboard;
    bit               at_start;
    bit               start_ok;
    bit [2:0]         raw_seen;
    bit               esc_pend;
    bit               stopped;
    bit [7:0]         hold_pair [2];
    bit [1:0]         hold_cnt;
    bit [LEN_W-1:0]   emitted_cnt;
    bit [15:0]        crc_acc;
    deframe_result_t  expected_q[$];
    int               errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      at_start     = 1'b1;
      start_ok     = 1'b0;
      raw_seen     = '0;
      esc_pend     = 1'b0;
      stopped      = 1'b0;
      hold_pair[0] = '0;
      hold_pair[1] = '0;
      hold_cnt     = '0;
      emitted_cnt  = '0;
      crc_acc      = CRC_INIT;
    endfunction

    // Shift one decoded byte through the hold pair; the oldest leaves as payload.
    function void push_decoded(bit [7:0] d);
      deframe_result_t r;
      if (hold_cnt >= 2) begin
        r = '0;
        r.payload_byte  = hold_pair[0];
        r.payload_valid = 1'b1;
        crc_acc = crc16_x25_advance(crc_acc, hold_pair[0]);
        if (emitted_cnt < LEN_MAX) emitted_cnt++;
        hold_pair[0] = hold_pair[1];
        hold_pair[1] = d;
        expected_q.push_back(r);
      end else begin
        hold_pair[hold_cnt[0]] = d;
        hold_cnt++;
      end
    endfunction

    function void note_input(bit [7:0] b, bit eob);
      deframe_result_t r;
      bit [3:0]        total;
      bit [15:0]       rx_fcs;
      if (eob) begin
        r = '0;
        r.frame_done = 1'b1;
        total = raw_seen + 4'd1;
        if (total < 4 || !(start_ok && !at_start) || b != FLAG_BYTE) begin
          r.frame_status = STAT_INVALID;
        end else if (esc_pend && !stopped) begin
          r.frame_status = STAT_BAD_ESC;
        end else if (hold_cnt < 2) begin
          r.frame_status = STAT_INVALID;
        end else begin
          rx_fcs = {hold_pair[1], hold_pair[0]};
          r.frame_status   = (rx_fcs == ~crc_acc) ? STAT_OK : STAT_CRC_ERR;
          r.payload_length = emitted_cnt;
        end
        expected_q.push_back(r);
        clear_frame();
        return;
      end
      if (raw_seen < 7) raw_seen++;
      if (at_start) begin
        at_start = 1'b0;
        start_ok = (b == FLAG_BYTE);
        return;
      end
      if (!start_ok || stopped) return;
      if (esc_pend) begin
        esc_pend = 1'b0;
        push_decoded(b ^ ESC_XOR);
      end else if (b == ESC_BYTE) begin
        esc_pend = 1'b1;
      end else if (b == FLAG_BYTE) begin
        stopped = 1'b1;
      end else begin
        push_decoded(b);
      end
    endfunction

    function void cmp(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(deframe_result_t got);
      deframe_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      cmp("payload_byte", want.payload_byte, got.payload_byte);
      cmp("payload_valid", want.payload_valid, got.payload_valid);
      cmp("frame_done", want.frame_done, got.frame_done);
      cmp("frame_status", want.frame_status, got.frame_status);
      cmp("payload_length", want.payload_length, got.payload_length);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hdlcd_in_if  in_ch();
  hdlcd_out_if out_ch();

  async_hdlc_deframer_crc16_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deframe_scoreboard sb = new();

  // Stimulus controls shared between the sender and the receiver.
  bit          gaps_on;     // sender may insert idle bursts in this frame
  bit          quiet;       // final stretch: no idling on either side
  bit          stall_req;   // ask the receiver for one long hold-off
  bit          extra_esc;   // escape ordinary bytes now and then
  byte_q_t     frame_q;     // raw bytes of the buffer being built
  int unsigned cycle_count;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Stop a hung run; the limit covers the slowest legal run several times over.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Sample both handshakes at the edge; check results before noting new input.
  always @(posedge clk) begin
    deframe_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.payload_byte   = out_ch.payload_byte;
        got.payload_valid  = out_ch.payload_valid;
        got.frame_done     = out_ch.frame_done;
        got.frame_status   = out_ch.frame_status;
        got.payload_length = out_ch.payload_length;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.rx_byte, in_ch.end_of_buffer);
    end
  end

  // Receiver: short random stall bursts, one long hold-off on request,
  // and steady ready once the run goes quiet.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Random byte biased toward the flag and the escape so stuffing is exercised.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 15))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_q_t rand_payload(int unsigned n);
    byte_q_t q;
    for (int unsigned i = 0; i < n; i++) q.push_back(rand_byte());
    return q;
  endfunction

  function automatic frame_kind_t pick_kind(int unsigned r);
    if (r < 55) return FK_GOOD;
    if (r < 65) return FK_CRC_ERR;
    if (r < 73) return FK_INNER_FLAG;
    if (r < 79) return FK_DANGLING_ESC;
    if (r < 85) return FK_BAD_END;
    if (r < 90) return FK_BAD_START;
    return FK_NOISE;
  endfunction

  // Stuff one decoded byte into the raw buffer.
  function automatic void add_stuffed(logic [7:0] d);
    if (d == FLAG_BYTE || d == ESC_BYTE || (extra_esc && $urandom_range(0, 15) == 0)) begin
      frame_q.push_back(ESC_BYTE);
      frame_q.push_back(d ^ ESC_XOR);
    end else begin
      frame_q.push_back(d);
    end
  endfunction

  // Build a flagged frame around the payload with its FCS; optionally corrupt the FCS.
  function automatic void build_frame(byte_q_t payload, bit bad_fcs);
    logic [15:0] crc;
    logic [15:0] fcs;
    frame_q.delete();
    frame_q.push_back(FLAG_BYTE);
    crc = CRC_INIT;
    foreach (payload[i]) begin
      crc = crc16_x25_advance(crc, payload[i]);
      add_stuffed(payload[i]);
    end
    fcs = ~crc;
    if (bad_fcs) fcs = fcs ^ (16'h1 << $urandom_range(0, 15));
    add_stuffed(fcs[7:0]);
    add_stuffed(fcs[15:8]);
    frame_q.push_back(FLAG_BYTE);
  endfunction

  // Offer one item and hold it until the block takes it; idle first at random.
  task automatic send_item(logic [7:0] b, logic eob);
    if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.rx_byte       <= b;
    in_ch.end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_item(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Drop valid and wait until every pending result has come out.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    byte_q_t     fixed;
    frame_kind_t kind;
    int unsigned len;
    int unsigned frame_no;
    int unsigned random_items;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.rx_byte       <= '0;
    in_ch.end_of_buffer <= 1'b0;
    gaps_on   = 1'b1;
    quiet     = 1'b0;
    stall_req = 1'b0;
    extra_esc = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed buffers.
    // Lone flag on the final byte: short buffer.
    frame_q = {FLAG_BYTE};
    send_frame();
    // Empty payload with a correct FCS of zero.
    fixed.delete();
    build_frame(fixed, 1'b0);
    send_frame();
    // Byte extremes plus a flag value inside the payload, escaped.
    fixed = {8'h00, 8'hFF, FLAG_BYTE};
    build_frame(fixed, 1'b0);
    send_frame();
    // Escape followed by a raw flag decodes as data and does not stop.
    frame_q = {FLAG_BYTE, ESC_BYTE, FLAG_BYTE, 8'h41, 8'h42, FLAG_BYTE};
    send_frame();
    // Escape dangling right before the closing flag.
    frame_q = {FLAG_BYTE, 8'h11, 8'h22, ESC_BYTE, FLAG_BYTE};
    send_frame();
    // Bad opening flag: everything up to the end is ignored.
    frame_q = {8'h00, 8'h11, 8'h22, FLAG_BYTE};
    send_frame();

    // Random buffers.
    extra_esc    = 1'b1;
    frame_no     = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      frame_no++;
      gaps_on = ($urandom_range(0, 3) != 0);
      if (random_items >= QUIET_FROM) quiet = 1'b1;
      if (frame_no == 15) begin
        // Hold the receiver off and keep offering items so the block backs up.
        stall_req = 1'b1;
        gaps_on   = 1'b0;
        build_frame(rand_payload(40), 1'b0);
      end else if (frame_no == 30) begin
        // One long frame drives the payload count into saturation.
        build_frame(rand_payload(MAX_PAYLOAD + 4), 1'b0);
      end else begin
        kind = pick_kind($urandom_range(0, 99));
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(0, 16);
        case (kind)
          FK_GOOD: begin
            build_frame(rand_payload(len), 1'b0);
          end
          FK_CRC_ERR: begin
            build_frame(rand_payload(len), 1'b1);
          end
          FK_INNER_FLAG: begin
            build_frame(rand_payload(len), 1'b0);
            frame_q.insert($urandom_range(1, frame_q.size() - 1), FLAG_BYTE);
          end
          FK_DANGLING_ESC: begin
            build_frame(rand_payload(len), 1'b0);
            frame_q.insert(frame_q.size() - 1, ESC_BYTE);
          end
          FK_BAD_END: begin
            build_frame(rand_payload(len), 1'b0);
            frame_q[frame_q.size() - 1] = 8'($urandom_range(0, 255));
          end
          FK_BAD_START: begin
            build_frame(rand_payload(len), 1'b0);
            frame_q[0] = 8'($urandom_range(0, 255));
          end
          default: begin
            // Noise, short buffers among them.
            frame_q.delete();
            repeat ($urandom_range(1, 12)) frame_q.push_back(rand_byte());
          end
        endcase
      end
      send_frame();
      if (frame_no != 30) random_items += frame_q.size();
      // Let the sender go idle until the block has fully drained once.
      if (frame_no == 45) hold_until_drained();
    end

    // Wait for every result, then keep idling to catch anything stray.
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
